FILE: rtl/jsu_pkg.sv
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  typedef struct packed {
    logic [15:0] ch;
    logic        fin;
    logic        bad;
  } res_t;

  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_U      = 16'h0075;
  localparam logic [15:0] CH_0      = 16'h0030;
  localparam logic [15:0] CH_9      = 16'h0039;
  localparam logic [15:0] CH_UA     = 16'h0041;
  localparam logic [15:0] CH_UF     = 16'h0046;
  localparam logic [15:0] CH_LA     = 16'h0061;
  localparam logic [15:0] CH_LF     = 16'h0066;
  localparam logic [15:0] CH_B      = 16'h0062;
  localparam logic [15:0] CH_T      = 16'h0074;
  localparam logic [15:0] CH_N      = 16'h006E;
  localparam logic [15:0] CH_F      = 16'h0066;
  localparam logic [15:0] CH_R      = 16'h0072;
  localparam logic [15:0] CH_DQUOTE = 16'h0022;
  localparam logic [15:0] CH_SQUOTE = 16'h0027;
  localparam logic [15:0] CH_BS     = 16'h0008;
  localparam logic [15:0] CH_TAB    = 16'h0009;
  localparam logic [15:0] CH_LF_C   = 16'h000A;
  localparam logic [15:0] CH_FF     = 16'h000C;
  localparam logic [15:0] CH_CR     = 16'h000D;
  localparam logic [2:0]  HEX_LEN   = 3'd4;

  // Hex digit value; anything else passes through raw.
  function automatic logic [15:0] digit_value(input logic [15:0] c);
    logic [15:0] v;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = c - (CH_UA - 16'd10);
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = c - (CH_LA - 16'd10);
    end else begin
      v = c;
    end
    return v;
  endfunction

  // Escape letter to character, 0 when not a simple escape.
  function automatic logic [15:0] escape_of(input logic [15:0] c);
    logic [15:0] e;
    case (c)
      CH_B:      e = CH_BS;
      CH_T:      e = CH_TAB;
      CH_N:      e = CH_LF_C;
      CH_F:      e = CH_FF;
      CH_R:      e = CH_CR;
      CH_DQUOTE: e = CH_DQUOTE;
      CH_SQUOTE: e = CH_SQUOTE;
      default:   e = 16'd0;
    endcase
    return e;
  endfunction

endpackage

FILE: rtl/json_string_unescape.sv
// Streaming unescaper for the body of a quoted string, one 16-bit code unit per
// word. Simple escapes (\b \t \n \f \r \" \') and \u plus four digits are
// folded into single code units; a backslash before any other unit is passed
// through and that unit is handled as usual. The block takes one word per
// cycle while no stall or pending result holds it: a word lands in an input
// register, is decoded by short logic against the escape state, and its result
// goes to the output register. A stalled output holds the decode, so once the
// input register is full, in_ready drops until the output word is taken. The one
// case with two results (unknown escape followed by a plain unit) parks the
// second result in a pending register, which is sent before any new word is
// decoded. A string that ends inside \u gives a single result with char_out 0,
// final_res 1, malformed 1; the consumer should drop the whole string.
module json_string_unescape (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_char_in,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_char_out,
  output logic        out_final_res,
  output logic        out_malformed
);
  import jsu_pkg::*;

  // input register
  logic        in_vld_r;
  logic [15:0] in_c_r;
  logic        in_fin_r;

  // escape state
  mode_t       mode_r, mode_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;

  // output and pending result
  logic        out_vld_r;
  res_t        out_r;
  logic        pend_vld_r;
  res_t        pend_r;

  // decode results
  res_t        r0, r1;
  logic [1:0]  n_res;
  logic        slot_free;
  logic        consume;
  logic [15:0] esc;
  logic [15:0] acc_sh;
  logic [2:0]  cnt_inc;

  assign slot_free = !out_vld_r || out_ready;
  assign consume   = in_vld_r && !pend_vld_r && slot_free;
  assign in_ready  = !in_vld_r || consume;

  assign esc     = escape_of(in_c_r);
  assign acc_sh  = {acc_r[11:0], 4'b0000} | digit_value(in_c_r);
  assign cnt_inc = cnt_r + 3'd1;

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    r0       = '0;
    r1       = '0;
    n_res    = 2'd0;
    case (mode_r)
      MODE_ESCAPE: begin
        mode_nxt = MODE_NORMAL;
        if (in_c_r == CH_U) begin
          mode_nxt = MODE_HEX;
          cnt_nxt  = 3'd0;
          acc_nxt  = 16'd0;
          if (in_fin_r) begin
            r0    = '{ch: 16'd0, fin: 1'b1, bad: 1'b1};
            n_res = 2'd1;
          end
        end else if (esc != 16'd0) begin
          r0    = '{ch: esc, fin: in_fin_r, bad: 1'b0};
          n_res = 2'd1;
        end else begin
          // unknown escape: backslash out, then the unit as a normal one
          r0 = '{ch: CH_BSLASH, fin: 1'b0, bad: 1'b0};
          if (in_c_r == CH_BSLASH && !in_fin_r) begin
            mode_nxt = MODE_ESCAPE;
            n_res    = 2'd1;
          end else begin
            r1    = '{ch: in_c_r, fin: in_fin_r, bad: 1'b0};
            n_res = 2'd2;
          end
        end
      end
      MODE_HEX: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= HEX_LEN) begin
          r0       = '{ch: acc_sh, fin: in_fin_r, bad: 1'b0};
          n_res    = 2'd1;
          mode_nxt = MODE_NORMAL;
          cnt_nxt  = 3'd0;
          acc_nxt  = 16'd0;
        end else if (in_fin_r) begin
          r0    = '{ch: 16'd0, fin: 1'b1, bad: 1'b1};
          n_res = 2'd1;
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        if (in_c_r == CH_BSLASH && !in_fin_r) begin
          mode_nxt = MODE_ESCAPE;
        end else begin
          r0    = '{ch: in_c_r, fin: in_fin_r, bad: 1'b0};
          n_res = 2'd1;
        end
      end
    endcase
    if (in_fin_r) begin
      mode_nxt = MODE_NORMAL;
      cnt_nxt  = 3'd0;
      acc_nxt  = 16'd0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_c_r   <= in_char_in;
      in_fin_r <= in_end_of_string;
    end
  end

  // escape state advances when a word is decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      cnt_r  <= 3'd0;
      acc_r  <= 16'd0;
    end else if (consume) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // output register; pending result goes first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else if (pend_vld_r && slot_free) begin
      out_vld_r  <= 1'b1;
      pend_vld_r <= 1'b0;
    end else if (consume && n_res != 2'd0) begin
      out_vld_r  <= 1'b1;
      pend_vld_r <= (n_res == 2'd2);
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_vld_r && slot_free) begin
      out_r <= pend_r;
    end else if (consume && n_res != 2'd0) begin
      out_r <= r0;
      pend_r <= r1;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_char_out  = out_r.ch;
  assign out_final_res = out_r.fin;
  assign out_malformed = out_r.bad;

  // a pending result only exists behind a held output word
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> out_vld_r)
    else $error("pending result without output word");

  // the second result is never an error report
  a_pend_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> !pend_r.bad)
    else $error("pending result flagged malformed");

  // an error report always closes the string
  a_bad_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.bad |-> out_r.fin && out_r.ch == 16'd0)
    else $error("malformed result not final or nonzero");

  // escape state is clean after the last word of a string
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    consume && in_fin_r |=> mode_r == MODE_NORMAL && cnt_r == 3'd0 && acc_r == 16'd0)
    else $error("escape state not cleared at end of string");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import jsu_pkg::*;

  // Sender side: random bursts; one random string is sent before the next.
  localparam int RANDOM_UNITS = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_char_in = 16'd0;
  logic        in_end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_char_out;
  logic        out_final_res;
  logic        out_malformed;

  json_string_unescape dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_in       (in_char_in),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char_out     (out_char_out),
    .out_final_res    (out_final_res),
    .out_malformed    (out_malformed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Unescape predictor: own copy of the escape state, one call per accepted
  // word, appends the decoded words it completes to the expected queue.
  // ---------------------------------------------------------------------------
  mode_t       esc_mode = MODE_NORMAL;
  logic [2:0]  hex_count = 3'd0;
  logic [15:0] hex_acc = 16'd0;
  res_t        decoded_q[$];

  int err_count = 0;
  int units_sent = 0;
  int strings_sent = 0;
  int results_seen = 0;
  int malformed_seen = 0;

  // Hex digit to its value; a non-digit is ORed in as its raw code.
  function automatic logic [15:0] hex_nibble(input logic [15:0] c);
    if (c >= CH_0 && c <= CH_9) return c - CH_0;
    if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 16'd10;
    if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 16'd10;
    return c;
  endfunction

  // Single-letter escapes; 0 means "not one of them".
  function automatic logic [15:0] simple_escape(input logic [15:0] c);
    case (c)
      CH_B:      return CH_BS;
      CH_T:      return CH_TAB;
      CH_N:      return CH_LF_C;
      CH_F:      return CH_FF;
      CH_R:      return CH_CR;
      CH_DQUOTE: return CH_DQUOTE;
      CH_SQUOTE: return CH_SQUOTE;
      default:   return 16'd0;
    endcase
  endfunction

  function automatic void push_decoded(input logic [15:0] c, input logic fin,
                                       input logic bad);
    decoded_q.push_back({c, fin, bad});
  endfunction

  // Plain word: a non-final backslash opens an escape, anything else passes.
  function automatic void take_plain(input logic [15:0] c, input logic fin);
    if (c == CH_BSLASH && !fin) begin
      esc_mode = MODE_ESCAPE;
    end else begin
      push_decoded(c, fin, 1'b0);
    end
  endfunction

  function automatic void predict_unit(input logic [15:0] c, input logic fin);
    logic [15:0] esc;
    case (esc_mode)
      MODE_ESCAPE: begin
        esc_mode = MODE_NORMAL;
        esc = simple_escape(c);
        if (c == CH_U) begin
          esc_mode = MODE_HEX;
          hex_count = 3'd0;
          hex_acc = 16'd0;
          // string ends right after \u
          if (fin) push_decoded(16'd0, 1'b1, 1'b1);
        end else if (esc != 16'd0) begin
          push_decoded(esc, fin, 1'b0);
        end else begin
          // unknown escape: backslash out, then the word as a plain one
          push_decoded(CH_BSLASH, 1'b0, 1'b0);
          take_plain(c, fin);
        end
      end
      MODE_HEX: begin
        hex_acc = (hex_acc << 4) | hex_nibble(c);
        hex_count = hex_count + 3'd1;
        if (hex_count >= HEX_LEN) begin
          push_decoded(hex_acc, fin, 1'b0);
          esc_mode = MODE_NORMAL;
          hex_count = 3'd0;
          hex_acc = 16'd0;
        end else if (fin) begin
          push_decoded(16'd0, 1'b1, 1'b1);
        end
      end
      default: begin
        esc_mode = MODE_NORMAL;
        take_plain(c, fin);
      end
    endcase
    if (fin) begin
      esc_mode = MODE_NORMAL;
      hex_count = 3'd0;
      hex_acc = 16'd0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall pattern switches now and then to a randomly chosen style
  // (always ready, coin flip, one in four, rare stalls).
  // ---------------------------------------------------------------------------
  int stall_style = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left = stall_left - 1;
    case (stall_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 1);
      2:       out_ready <= (stall_left % 4 == 0);
      default: out_ready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // Result check: each accepted word against the oldest expected one.
  res_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_malformed) malformed_seen++;
      if (decoded_q.size() == 0) begin
        $error("unexpected output word: char_out %h final_res %b malformed %b",
               out_char_out, out_final_res, out_malformed);
        err_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_char_out !== want.ch) begin
          $error("char_out: expected %h, got %h", want.ch, out_char_out);
          err_count++;
        end
        if (out_final_res !== want.fin) begin
          $error("final_res: expected %b, got %b", want.fin, out_final_res);
          err_count++;
        end
        if (out_malformed !== want.bad) begin
          $error("malformed: expected %b, got %b", want.bad, out_malformed);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  int          burst_left = 0;
  logic [15:0] text_q[$];

  // One word; opens a new burst (maybe after a gap) when the last one ran out.
  task automatic send_unit(input logic [15:0] c, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_char_in <= c;
    in_end_of_string <= fin;
    do @(posedge clk); while (!in_ready);
    predict_unit(c, fin);
    units_sent++;
  endtask

  // Sends text_q as one string, end marker on its last word.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_unit(text_q[i], i == text_q.size() - 1);
    end
    strings_sent++;
  endtask

  function automatic logic [15:0] rand_bits16();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  // Mostly printable ASCII, with controls and full 16-bit values mixed in.
  function automatic logic [15:0] rand_plain();
    logic [15:0] c;
    case ($urandom_range(0, 3))
      0, 1:    c = 16'h0020 + 16'($urandom_range(0, 94));
      2:       c = rand_bits16();
      default: c = 16'($urandom_range(0, 31));
    endcase
    return c;
  endfunction

  // \u digit: either case of hex, or now and then a raw junk word.
  function automatic logic [15:0] rand_digit();
    logic [15:0] c;
    case ($urandom_range(0, 7))
      0, 1, 2: c = CH_0 + 16'($urandom_range(0, 9));
      3, 4:    c = CH_UA + 16'($urandom_range(0, 5));
      5, 6:    c = CH_LA + 16'($urandom_range(0, 5));
      default: c = rand_bits16();
    endcase
    return c;
  endfunction

  function automatic logic [15:0] rand_escape_letter();
    case ($urandom_range(0, 6))
      0:       return CH_B;
      1:       return CH_T;
      2:       return CH_N;
      3:       return CH_F;
      4:       return CH_R;
      5:       return CH_DQUOTE;
      default: return CH_SQUOTE;
    endcase
  endfunction

  // Mostly well-formed strings with random content and endings that
  // sometimes cut a \u short or stop on a backslash; some pure noise.
  task automatic build_random_text();
    int n_tokens;
    int n_digits;
    text_q = {};
    if ($urandom_range(0, 9) == 0) begin
      n_tokens = $urandom_range(1, 10);
      repeat (n_tokens) begin
        case ($urandom_range(0, 3))
          0:       text_q.push_back(CH_BSLASH);
          1:       text_q.push_back(CH_U);
          2:       text_q.push_back(rand_digit());
          default: text_q.push_back(rand_bits16());
        endcase
      end
    end else begin
      n_tokens = $urandom_range(0, 10);
      repeat (n_tokens) begin
        case ($urandom_range(0, 7))
          0, 1, 2: text_q.push_back(rand_plain());
          3: begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(rand_escape_letter());
          end
          4, 5: begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(CH_U);
            repeat (4) text_q.push_back(rand_digit());
          end
          default: begin
            // backslash + arbitrary word; may land on a real escape too
            text_q.push_back(CH_BSLASH);
            text_q.push_back(rand_plain());
          end
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          n_digits = $urandom_range(0, 3);
          text_q.push_back(CH_BSLASH);
          text_q.push_back(CH_U);
          repeat (n_digits) text_q.push_back(rand_digit());
        end
        2: text_q.push_back(CH_BSLASH);
        default: if (text_q.size() == 0) text_q.push_back(rand_plain());
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_simple_escapes();
    text_q = {CH_BSLASH, CH_B, CH_BSLASH, CH_T, CH_BSLASH, CH_N, CH_BSLASH, CH_F,
              CH_BSLASH, CH_R, CH_BSLASH, CH_DQUOTE, CH_BSLASH, CH_SQUOTE};
    send_text();
  endtask

  // Digit range edges, a raw non-hex digit, then plain extremes.
  task automatic test_unicode_escapes();
    text_q = {CH_BSLASH, CH_U, CH_0, CH_LF, CH_UA, 16'hFFFF, 16'hFFFF, 16'h0000};
    send_text();
  endtask

  // String ends right after \u, and after one digit.
  task automatic test_truncated_unicode();
    text_q = {CH_BSLASH, CH_U};
    send_text();
    text_q = {CH_BSLASH, CH_U, CH_9};
    send_text();
  endtask

  // Lone final backslash; unknown escape; backslash-backslash reopening an
  // escape; a final backslash right after a backslash.
  task automatic test_backslash_passthrough();
    text_q = {CH_BSLASH};
    send_text();
    text_q = {CH_BSLASH, 16'h0000, CH_BSLASH, CH_BSLASH, CH_BSLASH};
    send_text();
  endtask

  task automatic test_random_strings();
    int first_unit;
    first_unit = units_sent;
    while (units_sent - first_unit < RANDOM_UNITS) begin
      build_random_text();
      send_text();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_simple_escapes();
    test_unicode_escapes();
    test_truncated_unicode();
    test_backslash_passthrough();
    test_random_strings();

    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d strings (%0d words in, %0d words out, %0d flagged malformed).",
             strings_sent, units_sent, results_seen, malformed_seen);
    $display("Simple and unicode escapes, cut-short unicode, backslash pass-through,");
    $display("then random strings with random input gaps and output stalls.");
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
